FILE: rtl/aat_pkg.sv
// ----------------------------------------------------------------------------
// aat_pkg
// Shared types and constants of the annular arc tessellator.
// ----------------------------------------------------------------------------
package aat_pkg;

  localparam int MAX_SEGMENTS   = 32;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 1;
  localparam int SEG_W          = $clog2(MAX_SEGMENTS + 1);
  localparam int PPC_W          = 11;
  localparam int ANG_W          = 16;
  localparam int COORD_W        = 20;
  localparam int DIV_STEPS      = ANG_W;

  // quarter wave polynomial coefficients, Q30
  localparam logic [31:0] POLY_A = 32'd1686629713;
  localparam logic [31:0] POLY_B = 32'd688904866;
  localparam logic [31:0] POLY_C = 32'd76016977;

  localparam logic [PPC_W-1:0] PPC_RESET = 11'd64;

  // sine evaluation steps
  localparam logic [2:0] TS_SQUARE = 3'd0;
  localparam logic [2:0] TS_MUL_C  = 3'd1;
  localparam logic [2:0] TS_MUL_B  = 3'd2;
  localparam logic [2:0] TS_MUL_A  = 3'd3;
  localparam logic [2:0] TS_ROUND  = 3'd4;
  // coordinate steps: four products, then the last store
  localparam logic [2:0] CS_LAST   = 3'd4;

  typedef enum logic [3:0] {
    DP_NOP, DP_LOAD, DP_SEGS, DP_DIV, DP_ANG0,
    DP_TRIG, DP_CRD, DP_TRI0, DP_TRI1, DP_NEXT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       sel;    // 0: cosine, 1: sine
    logic [2:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic first_vtx;
    logic last_vtx;
  } dp_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEGS, ST_DIV, ST_ANG0, ST_TRIG,
    ST_CRD, ST_TRI0, ST_TRI1, ST_NEXT
  } ctl_state_t;

endpackage

FILE: rtl/aat_datapath.sv
// ----------------------------------------------------------------------------
// aat_datapath
// Request registers, segment divider, shared multiplier, sine evaluation,
// vertex coordinates and the triangle output register.
// ----------------------------------------------------------------------------
module aat_datapath
  import aat_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [PPC_W-1:0]          cfg_wdata,
  input  logic [17:0]               in_center_x,
  input  logic [17:0]               in_center_y,
  input  logic [15:0]               in_radius,
  input  logic [13:0]               in_thickness,
  input  logic [15:0]               in_start_angle,
  input  logic [15:0]               in_end_angle,
  input  logic [31:0]               in_color,
  input  dp_cmd_t                   cmd,
  output dp_stat_t                  stat,
  output logic signed [COORD_W-1:0] out_first_x,
  output logic signed [COORD_W-1:0] out_first_y,
  output logic signed [COORD_W-1:0] out_second_x,
  output logic signed [COORD_W-1:0] out_second_y,
  output logic signed [COORD_W-1:0] out_third_x,
  output logic signed [COORD_W-1:0] out_third_y,
  output logic [31:0]               out_tri_color,
  output logic                      out_last_triangle
);

  localparam int RW = 18;
  localparam int PW = TRIG_W + RW;
  localparam int SW = PW + 2;
  localparam int TRIG_SHIFT = 44 - TRIG_FRAC_BITS;

  logic [PPC_W-1:0] ppc_r;
  logic [17:0]      cx_r, cy_r;
  logic [15:0]      sa_r, ea_r, rng_r;
  logic [31:0]      color_r;
  logic [RW-1:0]    rin_mag_r, rout_r;
  logic             rin_neg_r;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_r;

  logic [SEG_W-1:0] segs_r, div_rem_r, acc_rem_r, vidx_r;
  logic [15:0]      div_q_r, acc_q_r, ang_r;

  logic [14:0]       qa_r;
  logic              qneg_r;
  logic [30:0]       z2_r;
  logic [TRIG_W-1:0] cos_mag_r, sin_mag_r;
  logic              cos_neg_r, sin_neg_r, crd_neg_r;

  logic [COORD_W-1:0] cur_xin_r, cur_yin_r, cur_xout_r, cur_yout_r;
  logic [COORD_W-1:0] prv_xin_r, prv_yin_r, prv_xout_r, prv_yout_r;

  // load helpers
  logic [16:0] r2;
  logic [10:0] npts;

  // divider step
  logic [SEG_W:0]   rem_t;
  logic             q_bit;
  logic [SEG_W-1:0] rem_n;

  // sine helpers
  logic [15:0] tang;
  logic [14:0] qa;
  logic [63:0] rnd;

  // coordinate helpers
  logic [2:0]          kp;
  logic signed [SW-1:0] crd_s, crd_sh;
  logic [COORD_W-1:0]  crd_val;

  // next angle
  logic [SEG_W:0] acc_sum;
  logic [15:0]    acc_q_n;

  assign r2   = {in_radius, 1'b0};
  assign npts = prod_r[26:16];

  assign rem_t = {div_rem_r, div_q_r[15]};
  assign q_bit = (rem_t >= {1'b0, segs_r});
  assign rem_n = q_bit ? SEG_W'(rem_t - {1'b0, segs_r}) : rem_t[SEG_W-1:0];

  assign tang = cmd.sel ? ang_r : 16'(ang_r + 16'd16384);
  assign qa   = tang[14] ? 15'(15'd16384 - {1'b0, tang[13:0]}) : {1'b0, tang[13:0]};
  assign rnd  = prod_r + (64'd1 << (TRIG_SHIFT - 1));

  assign kp     = 3'(cmd.step - 3'd1);
  assign crd_s  = crd_neg_r ? -$signed({2'b0, prod_r[PW-1:0]})
                            :  $signed({2'b0, prod_r[PW-1:0]});
  assign crd_sh = (crd_s + (SW'(1) <<< TRIG_FRAC_BITS)) >>> (TRIG_FRAC_BITS + 1);
  assign crd_val = (kp[0] ? {2'b0, cy_r} : {2'b0, cx_r}) + crd_sh[COORD_W-1:0];

  assign acc_sum = {1'b0, acc_rem_r} + {1'b0, div_rem_r};
  assign acc_q_n = (acc_sum >= {1'b0, segs_r}) ? 16'(acc_q_r + div_q_r + 16'd1)
                                              : 16'(acc_q_r + div_q_r);

  assign stat.empty     = (ea_r <= sa_r);
  assign stat.first_vtx = (vidx_r == '0);
  assign stat.last_vtx  = (vidx_r == segs_r);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      DP_LOAD: begin
        mul_a = 32'(ppc_r);
        mul_b = 32'(16'(in_end_angle - in_start_angle));
      end
      DP_TRIG: begin
        unique case (cmd.step)
          TS_SQUARE: begin
            mul_a = 32'(qa);
            mul_b = 32'(qa);
          end
          TS_MUL_C: begin
            mul_a = POLY_C;
            mul_b = {1'b0, prod_r[28:0], 2'b00};
          end
          TS_MUL_B: begin
            mul_a = POLY_B - prod_r[61:30];
            mul_b = {1'b0, z2_r};
          end
          TS_MUL_A: begin
            mul_a = POLY_A - prod_r[61:30];
            mul_b = 32'(qa_r);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      DP_CRD: begin
        if (cmd.step != CS_LAST) begin
          mul_a = 32'(cmd.step[0] ? sin_mag_r : cos_mag_r);
          mul_b = 32'(cmd.step[1] ? rout_r : rin_mag_r);
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppc_r <= PPC_RESET;
    end else if (cfg_we) begin
      ppc_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
    unique case (cmd.op)
      DP_LOAD: begin
        cx_r    <= in_center_x;
        cy_r    <= in_center_y;
        sa_r    <= in_start_angle;
        ea_r    <= in_end_angle;
        rng_r   <= 16'(in_end_angle - in_start_angle);
        color_r <= in_color;
        rout_r  <= RW'(r2) + RW'(in_thickness);
        if (17'(in_thickness) > r2) begin
          rin_neg_r <= 1'b1;
          rin_mag_r <= RW'(17'(in_thickness) - r2);
        end else begin
          rin_neg_r <= 1'b0;
          rin_mag_r <= RW'(r2 - 17'(in_thickness));
        end
      end
      DP_SEGS: begin
        if (npts < 11'd2) begin
          segs_r <= SEG_W'(1);
        end else if (npts > 11'(MAX_SEGMENTS + 1)) begin
          segs_r <= SEG_W'(MAX_SEGMENTS);
        end else begin
          segs_r <= SEG_W'(npts - 11'd1);
        end
        div_rem_r <= '0;
        div_q_r   <= rng_r;
      end
      DP_DIV: begin
        div_q_r   <= {div_q_r[14:0], q_bit};
        div_rem_r <= rem_n;
      end
      DP_ANG0: begin
        acc_q_r   <= '0;
        acc_rem_r <= '0;
        ang_r     <= sa_r;
        vidx_r    <= '0;
      end
      DP_TRIG: begin
        unique case (cmd.step)
          TS_SQUARE: begin
            qa_r   <= qa;
            qneg_r <= tang[15];
          end
          TS_MUL_C: z2_r <= {prod_r[28:0], 2'b00};
          TS_ROUND: begin
            if (cmd.sel) begin
              sin_mag_r <= rnd[TRIG_SHIFT +: TRIG_W];
              sin_neg_r <= qneg_r;
            end else begin
              cos_mag_r <= rnd[TRIG_SHIFT +: TRIG_W];
              cos_neg_r <= qneg_r;
            end
          end
          default: ;
        endcase
      end
      DP_CRD: begin
        if (cmd.step != CS_LAST) begin
          crd_neg_r <= (cmd.step[0] ? sin_neg_r : cos_neg_r) ^
                       (cmd.step[1] ? 1'b0 : rin_neg_r);
        end
        if (cmd.step != '0) begin
          unique case (kp[1:0])
            2'd0: cur_xin_r  <= crd_val;
            2'd1: cur_yin_r  <= crd_val;
            2'd2: cur_xout_r <= crd_val;
            2'd3: cur_yout_r <= crd_val;
          endcase
        end
      end
      DP_TRI0: begin
        out_first_x       <= prv_xin_r;
        out_first_y       <= prv_yin_r;
        out_second_x      <= prv_xout_r;
        out_second_y      <= prv_yout_r;
        out_third_x       <= cur_xin_r;
        out_third_y       <= cur_yin_r;
        out_tri_color     <= color_r;
        out_last_triangle <= 1'b0;
      end
      DP_TRI1: begin
        out_first_x       <= prv_xout_r;
        out_first_y       <= prv_yout_r;
        out_second_x      <= cur_xout_r;
        out_second_y      <= cur_yout_r;
        out_third_x       <= cur_xin_r;
        out_third_y       <= cur_yin_r;
        out_tri_color     <= color_r;
        out_last_triangle <= stat.last_vtx;
      end
      DP_NEXT: begin
        prv_xin_r  <= cur_xin_r;
        prv_yin_r  <= cur_yin_r;
        prv_xout_r <= cur_xout_r;
        prv_yout_r <= cur_yout_r;
        acc_q_r    <= acc_q_n;
        acc_rem_r  <= (acc_sum >= {1'b0, segs_r}) ? SEG_W'(acc_sum - {1'b0, segs_r})
                                                  : acc_sum[SEG_W-1:0];
        ang_r      <= 16'(sa_r + acc_q_n);
        vidx_r     <= SEG_W'(vidx_r + SEG_W'(1));
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/aat_ctrl.sv
// ----------------------------------------------------------------------------
// aat_ctrl
// Sequencer: request intake, divider steps, per vertex sine and coordinate
// steps, and triangle hand-off to the output register.
// ----------------------------------------------------------------------------
module aat_ctrl
  import aat_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  ctl_state_t state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       sel_r, sel_nxt;
  logic       outv_r, outv_nxt;
  logic       slot_free;

  assign slot_free = !outv_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = outv_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sel_nxt   = sel_r;
    outv_nxt  = outv_r && out_stall;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SEGS;
      ST_SEGS: begin
        state_nxt = stat.empty ? ST_IDLE : ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        cnt_nxt = 4'(cnt_r + 4'd1);
        if (cnt_r == 4'(DIV_STEPS - 1)) state_nxt = ST_ANG0;
      end
      ST_ANG0, ST_NEXT: begin
        state_nxt = ST_TRIG;
        cnt_nxt   = '0;
        sel_nxt   = 1'b0;
      end
      ST_TRIG: begin
        if (cnt_r[2:0] == TS_ROUND) begin
          cnt_nxt = '0;
          sel_nxt = 1'b1;
          if (sel_r) state_nxt = ST_CRD;
        end else begin
          cnt_nxt = 4'(cnt_r + 4'd1);
        end
      end
      ST_CRD: begin
        if (cnt_r[2:0] == CS_LAST) begin
          state_nxt = stat.first_vtx ? ST_NEXT : ST_TRI0;
        end else begin
          cnt_nxt = 4'(cnt_r + 4'd1);
        end
      end
      ST_TRI0: begin
        if (slot_free) begin
          outv_nxt  = 1'b1;
          state_nxt = ST_TRI1;
        end
      end
      ST_TRI1: begin
        if (slot_free) begin
          outv_nxt  = 1'b1;
          state_nxt = stat.last_vtx ? ST_IDLE : ST_NEXT;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = DP_NOP;
    cmd.sel  = sel_r;
    cmd.step = cnt_r[2:0];
    unique case (state_r)
      ST_IDLE: if (in_valid) cmd.op = DP_LOAD;
      ST_SEGS: cmd.op = DP_SEGS;
      ST_DIV:  cmd.op = DP_DIV;
      ST_ANG0: cmd.op = DP_ANG0;
      ST_TRIG: cmd.op = DP_TRIG;
      ST_CRD:  cmd.op = DP_CRD;
      ST_TRI0: if (slot_free) cmd.op = DP_TRI0;
      ST_TRI1: if (slot_free) cmd.op = DP_TRI1;
      ST_NEXT: cmd.op = DP_NEXT;
      default: cmd.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      sel_r   <= 1'b0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sel_r   <= sel_nxt;
      outv_r  <= outv_nxt;
    end
  end

endmodule

FILE: rtl/annular_arc_tessellator_unit.sv
// ----------------------------------------------------------------------------
// annular_arc_tessellator_unit
// Cuts a ring arc into quads and sends each quad out as two triangles.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one arc request per transaction. The
// block takes one request at a time; in_stall is high from the cycle after
// acceptance until the last triangle of the arc is in the output register.
// Output channel (out_valid/out_stall): one triangle per transaction, two
// per quad, out_last_triangle marks the end of the arc. The output register
// lets the next request be taken while the last triangle still waits.
// Per request, the block works through a 16 step divider for the angle
// increment, then per vertex five steps per sine or cosine and four
// products for the vertex coordinates, all on the one shared 32x32
// multiplier. An empty arc goes back to idle from the segment step.
// A stalled receiver holds the current triangle and pauses the sequencer.
// cfg_we writes points_per_circle; write it only while idle.
// Reset (rst_n, synchronous) empties the block and sets points_per_circle
// to 64.
// ----------------------------------------------------------------------------
module annular_arc_tessellator_unit
  import aat_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [PPC_W-1:0]          cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [17:0]               in_center_x,
  input  logic [17:0]               in_center_y,
  input  logic [15:0]               in_radius,
  input  logic [13:0]               in_thickness,
  input  logic [15:0]               in_start_angle,
  input  logic [15:0]               in_end_angle,
  input  logic [31:0]               in_color,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_first_x,
  output logic signed [COORD_W-1:0] out_first_y,
  output logic signed [COORD_W-1:0] out_second_x,
  output logic signed [COORD_W-1:0] out_second_y,
  output logic signed [COORD_W-1:0] out_third_x,
  output logic signed [COORD_W-1:0] out_third_y,
  output logic [31:0]               out_tri_color,
  output logic                      out_last_triangle
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  aat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  aat_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_center_x       (in_center_x),
    .in_center_y       (in_center_y),
    .in_radius         (in_radius),
    .in_thickness      (in_thickness),
    .in_start_angle    (in_start_angle),
    .in_end_angle      (in_end_angle),
    .in_color          (in_color),
    .cmd               (cmd),
    .stat              (stat),
    .out_first_x       (out_first_x),
    .out_first_y       (out_first_y),
    .out_second_x      (out_second_x),
    .out_second_y      (out_second_y),
    .out_third_x       (out_third_x),
    .out_third_y       (out_third_y),
    .out_tri_color     (out_tri_color),
    .out_last_triangle (out_last_triangle)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while previous one in flight");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_first_x) &&
      $stable(out_first_y) && $stable(out_second_x) && $stable(out_second_y) &&
      $stable(out_third_x) && $stable(out_third_y) && $stable(out_tri_color) &&
      $stable(out_last_triangle)))
    else $error("stalled triangle changed");

  a_no_tri_when_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> ##1 (!out_valid || $past(out_valid)))
    else $error("triangle issued right after request intake");

endmodule

FILE: bench/annular_arc_tessellator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// annular_arc_tessellator_unit_tb
// Feeds ring arc requests through a table of directed cases, then random
// arcs at several densities. Every triangle is checked field by field against
// an in-bench arc tessellation predictor. Both sides idle at random.
// ----------------------------------------------------------------------------
module annular_arc_tessellator_unit_tb;
  import aat_pkg::*;

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned K_A = PI_Q30 / 2;
  localparam longint unsigned K_B = PI_Q30 - (64'd5 << 29);
  localparam longint unsigned K_C = PI_Q30 / 2 - (64'd3 << 29);
  localparam int N_RANDOM = 260;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    bit [17:0] cx;
    bit [17:0] cy;
    bit [15:0] radius;
    bit [13:0] thick;
    bit [15:0] sa;
    bit [15:0] ea;
    bit [31:0] color;
  } arc_t;

  typedef struct {
    bit [COORD_W-1:0] x0, y0, x1, y1, x2, y2;
    bit [31:0]        color;
    bit               last;
  } tri_t;

  typedef struct {
    int   ppc;
    arc_t arc;
    int   n_tri;  // -1: no typed count
  } case_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [PPC_W-1:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [17:0] in_center_x = '0, in_center_y = '0;
  logic [15:0] in_radius = '0;
  logic [13:0] in_thickness = '0;
  logic [15:0] in_start_angle = '0, in_end_angle = '0;
  logic [31:0] in_color = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [COORD_W-1:0] out_first_x, out_first_y, out_second_x;
  logic signed [COORD_W-1:0] out_second_y, out_third_x, out_third_y;
  logic [31:0] out_tri_color;
  logic out_last_triangle;

  tri_t tri_q[$];
  int   ppc_model = 64;
  int   errors = 0;
  int   idle_cycles = 0;
  bit   busy_stretch = 0;

  annular_arc_tessellator_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_center_x(in_center_x), .in_center_y(in_center_y),
    .in_radius(in_radius), .in_thickness(in_thickness),
    .in_start_angle(in_start_angle), .in_end_angle(in_end_angle),
    .in_color(in_color),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_first_x(out_first_x), .out_first_y(out_first_y),
    .out_second_x(out_second_x), .out_second_y(out_second_y),
    .out_third_x(out_third_x), .out_third_y(out_third_y),
    .out_tri_color(out_tri_color), .out_last_triangle(out_last_triangle)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic longint sine_q15(bit [15:0] ang);
    longint unsigned z, z2, t;
    bit [13:0] a;
    a = ang[13:0];
    z = ang[14] ? (64'd16384 - a) << 16 : longint'(a) << 16;
    z2 = (z * z) >> 30;
    t = (K_C * z2) >> 30;
    t = K_B - t;
    t = (t * z2) >> 30;
    t = K_A - t;
    t = (t * z) >> 30;
    t = (t + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
    return ang[15] ? -longint'(t) : longint'(t);
  endfunction

  function automatic bit [COORD_W-1:0] ring_coord(bit [17:0] c, longint trig, longint r2);
    longint p;
    p = trig * r2 + (longint'(1) << TRIG_FRAC_BITS);
    p = longint'(c) + (p >>> (TRIG_FRAC_BITS + 1));
    return p[COORD_W-1:0];
  endfunction

  // returns number of triangles queued
  function automatic int tessellate_arc(arc_t a);
    longint unsigned rng, npts, segs, i;
    longint r_in, r_out, c1, s1, c2, s2;
    bit [15:0] a1, a2;
    tri_t t0, t1;
    bit [COORD_W-1:0] ix1, iy1, ox1, oy1, ix2, iy2, ox2, oy2;
    if (a.ea <= a.sa) return 0;
    rng = 64'(a.ea) - 64'(a.sa);
    npts = (longint'(ppc_model) * rng) >> 16;
    if (npts < 2) npts = 2;
    if (npts > MAX_SEGMENTS + 1) npts = MAX_SEGMENTS + 1;
    segs = npts - 1;
    r_in = 2 * longint'(a.radius) - longint'(a.thick);
    r_out = 2 * longint'(a.radius) + longint'(a.thick);
    for (i = 0; i < segs; i++) begin
      a1 = a.sa + 16'((i * rng) / segs);
      a2 = a.sa + 16'(((i + 1) * rng) / segs);
      c1 = sine_q15(a1 + 16'd16384); s1 = sine_q15(a1);
      c2 = sine_q15(a2 + 16'd16384); s2 = sine_q15(a2);
      ix1 = ring_coord(a.cx, c1, r_in);  iy1 = ring_coord(a.cy, s1, r_in);
      ox1 = ring_coord(a.cx, c1, r_out); oy1 = ring_coord(a.cy, s1, r_out);
      ix2 = ring_coord(a.cx, c2, r_in);  iy2 = ring_coord(a.cy, s2, r_in);
      ox2 = ring_coord(a.cx, c2, r_out); oy2 = ring_coord(a.cy, s2, r_out);
      t0 = '{ix1, iy1, ox1, oy1, ix2, iy2, a.color, 1'b0};
      t1 = '{ox1, oy1, ox2, oy2, ix2, iy2, a.color, i + 1 == segs};
      tri_q.push_back(t0);
      tri_q.push_back(t1);
    end
    return 2 * int'(segs);
  endfunction

  task automatic set_density(int ppc);
    wait (tri_q.size() == 0);
    repeat (60) @(negedge clk);
    cfg_we = 1;
    cfg_wdata = ppc[PPC_W-1:0];
    @(negedge clk);
    cfg_we = 0;
    ppc_model = ppc;
  endtask

  task automatic send_arc(arc_t a, int n_tri, bit may_idle);
    int n;
    if (may_idle && !busy_stretch && $urandom_range(99) < 26) begin
      in_valid = 0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid = 1;
    in_center_x = a.cx; in_center_y = a.cy;
    in_radius = a.radius; in_thickness = a.thick;
    in_start_angle = a.sa; in_end_angle = a.ea;
    in_color = a.color;
    do @(posedge clk); while (in_stall);
    n = tessellate_arc(a);
    if (n_tri >= 0 && n != n_tri) begin
      errors++;
      if (errors <= 10)
        $display("arc count: expected %0d triangles, predicted %0d", n_tri, n);
    end
    @(negedge clk);
    in_valid = 0;
  endtask

  always @(negedge clk)
    out_stall <= !busy_stretch && ($urandom_range(99) < 26);

  always @(posedge clk) begin
    tri_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (tri_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected triangle transaction");
      end else begin
        e = tri_q.pop_front();
        if (e.x0 !== out_first_x || e.y0 !== out_first_y ||
            e.x1 !== out_second_x || e.y1 !== out_second_y ||
            e.x2 !== out_third_x || e.y2 !== out_third_y ||
            e.color !== out_tri_color || e.last !== out_last_triangle) begin
          errors++;
          if (errors <= 10)
            $display("triangle mismatch: exp %h %h %h %h %h %h %h %b got %h %h %h %h %h %h %h %b",
                     e.x0, e.y0, e.x1, e.y1, e.x2, e.y2, e.color, e.last,
                     out_first_x, out_first_y, out_second_x, out_second_y,
                     out_third_x, out_third_y, out_tri_color, out_last_triangle);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("annular_arc_tessellator_unit_tb failed");
      $finish;
    end
  end

  case_t cases[] = '{
    '{64,   '{18'h0, 18'h0, 16'h0, 14'h0, 16'h0, 16'h0, 32'h0}, 0},
    '{64,   '{18'h1000, 18'h2000, 16'd500, 14'd20, 16'd100, 16'd50, 32'h1}, 0},
    '{64,   '{18'h1000, 18'h1000, 16'd800, 14'd40, 16'h0, 16'h1, 32'h12345678}, 2},
    '{64,   '{18'h3FFFF, 18'h3FFFF, 16'hFFFF, 14'h3FFF, 16'h0, 16'hFFFF,
              32'hFFFFFFFF}, 64},
    '{64,   '{18'h20000, 18'h20000, 16'd10, 14'd1000, 16'h0, 16'd16384,
              32'hA5A5A5A5}, 30},
    '{64,   '{18'h10000, 18'h30000, 16'd1000, 14'd0, 16'd16000, 16'd50000,
              32'h5A5A5A5A}, 64},
    '{64,   '{18'h0, 18'h3FFFF, 16'd3000, 14'd7, 16'hFFFE, 16'hFFFF, 32'hCAFE0001}, 2},
    '{64,   '{18'h0, 18'h0, 16'hFFFF, 14'h3FFF, 16'd30000, 16'd40000, 32'h0F0F0F0F}, 16},
    '{64,   '{18'h15555, 18'h2AAAA, 16'hAAAA, 14'h1555, 16'h5555, 16'hAAAA,
              32'h55AA55AA}, -1},
    '{0,    '{18'h8000, 18'h8000, 16'd4000, 14'd100, 16'h0, 16'hFFFF, 32'hDEADBEEF}, 2},
    '{0,    '{18'h8000, 18'h8000, 16'd4000, 14'd100, 16'd7, 16'd7, 32'h2}, 0},
    '{1024, '{18'h9000, 18'h7000, 16'd2000, 14'd50, 16'h0, 16'd64, 32'h3}, 2},
    '{1024, '{18'h9000, 18'h7000, 16'd2000, 14'd50, 16'h0, 16'd2048, 32'h4}, 62},
    '{1024, '{18'h9000, 18'h7000, 16'd2000, 14'd50, 16'hC000, 16'hFFFF, 32'h5}, 64},
    '{1,    '{18'h1234, 18'h4321, 16'd100, 14'd300, 16'h0, 16'hFFFF, 32'h6}, 2}
  };

  initial begin
    arc_t a;
    int n;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    foreach (cases[k]) begin
      if (cases[k].ppc != ppc_model) set_density(cases[k].ppc);
      send_arc(cases[k].arc, cases[k].n_tri, 1'b1);
    end
    for (n = 0; n < N_RANDOM; n++) begin
      in_valid = 0;
      if (n % 40 == 0) begin
        case ((n / 40) % 4)
          0: set_density($urandom_range(1024));
          1: set_density(1023);
          2: set_density($urandom_range(64, 2));
          default: set_density(1024);
        endcase
      end
      if (n == 130) wait (tri_q.size() == 0);
      busy_stretch = (n >= 60 && n < 100);
      a.cx = 18'($urandom); a.cy = 18'($urandom);
      a.radius = 16'($urandom); a.thick = 14'($urandom);
      a.color = $urandom;
      a.sa = 16'($urandom);
      if ($urandom_range(99) < 12)
        a.ea = 16'(a.sa - $urandom_range(a.sa));
      else if ($urandom_range(99) < 70 && a.sa != 16'hFFFF)
        a.ea = 16'(a.sa + $urandom_range(16'hFFFF - a.sa < 4096 ? 16'hFFFF - a.sa : 4096, 1));
      else
        a.ea = 16'($urandom);
      send_arc(a, -1, 1'b1);
    end
    in_valid = 0;
    busy_stretch = 0;
    wait (tri_q.size() == 0);
    repeat (700) @(posedge clk);
    if (errors == 0)
      $display("annular_arc_tessellator_unit_tb passed");
    else
      $display("annular_arc_tessellator_unit_tb failed");
    $finish;
  end

endmodule

FILE: annular_arc_tessellator_unit.f
rtl/aat_pkg.sv
rtl/aat_datapath.sv
rtl/aat_ctrl.sv
rtl/annular_arc_tessellator_unit.sv
bench/annular_arc_tessellator_unit_tb.sv
